[rtl/core/palu_pkg.sv]
// ----------------------------------------------------------------------------
// palu_pkg
// Types and constants shared by the passive-aggressive linear update block.
// ----------------------------------------------------------------------------
package palu_pkg;

   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_LOAD   = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [1:0] MODE_PA    = 2'd0;
   localparam logic [1:0] MODE_PA1   = 2'd1;
   localparam logic [1:0] MODE_PA2   = 2'd2;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   localparam logic [0:0] CSR_MODE = 1'd0;
   localparam logic [0:0] CSR_AGGR = 1'd1;

   localparam logic KIND_LOSS = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam logic [31:0] TAU_CAP = 32'hFFFF_FFFF;

   // divider request
   typedef struct packed {
      logic        start;
      logic [63:0] num;
      logic [63:0] den;
      logic [6:0]  frac_bits;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic        sat;
      logic [63:0] quo;
   } div_rsp_type;

endpackage

[rtl/core/palu_div.sv]
// ----------------------------------------------------------------------------
// palu_div
// Shared restoring divider: floor(num * 2^frac_bits / den), one quotient bit
// per cycle over 64 + frac_bits steps. The sat flag marks a quotient that
// does not fit in 64 bits.
// ----------------------------------------------------------------------------
module palu_div (
   input  logic                  clock,
   input  logic                  reset,
   input  palu_pkg::div_req_type req,
   output palu_pkg::div_rsp_type rsp
);

   logic [64:0]  rem_ff, rem_in;
   logic [63:0]  quo_ff, quo_in;
   logic [63:0]  num_ff, num_in;
   logic [63:0]  den_ff, den_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in;
   logic         sat_ff, sat_in;
   logic         done_ff, done_in;
   logic [64:0]  shifted;
   logic         ge;

   always_comb begin
      shifted = {rem_ff[63:0], num_ff[63]};
      ge      = shifted >= {1'b0, den_ff};
   end

   // one shift-subtract step per cycle
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      sat_in  = sat_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         quo_in  = '0;
         num_in  = req.num;
         den_in  = req.den;
         cnt_in  = 7'd64 + req.frac_bits;
         busy_in = 1'b1;
         sat_in  = 1'b0;
      end else if (busy_ff) begin
         rem_in = ge ? shifted - {1'b0, den_ff} : shifted;
         quo_in = {quo_ff[62:0], ge};
         num_in = {num_ff[62:0], 1'b0};
         sat_in = sat_ff | quo_ff[63];
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      num_ff <= num_in;
      den_ff <= den_in;
      sat_ff <= sat_in;
   end

   assign rsp.done = done_ff;
   assign rsp.sat  = sat_ff;
   assign rsp.quo  = quo_ff;

`ifndef SYNTHESIS
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done held");
   a_busy_clear: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider busy at done");
   a_cnt_run: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != 7'd0) else $error("divider count empty while busy");
`endif

endmodule

[rtl/core/passive_aggressive_linear_update_top.sv]
// Sequence: a load writes at accept; a read fetches the weight and returns it;
// a sample element fetches, multiplies, accumulates, and the last one divides for tau
// (PA-II: 0.5/C first; none at zero norm or PA-II zero C), then walks the weights.
// Throughput: one transaction at a time; req_stall is high while the sequencer is busy.
// Reset: synchronous, active high; a clearing walk over all DIM entries zeroes the weight
// memory after reset, during which no transaction is taken.
// ----------------------------------------------------------------------------
// passive_aggressive_linear_update_top
// Passive-aggressive online linear classifier (PA, PA-I, PA-II) in Q16.16, with
// three multipliers (dot product, square, update term) and one shared divider under a sequencer.
// ----------------------------------------------------------------------------
module passive_aggressive_linear_update_top #(
   parameter int DIM = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_element_index,
   input  logic signed [31:0] req_element_value,
   input  logic        req_class_label,
   input  logic        req_last_element,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic signed [31:0] rsp_result_value,
   output logic        rsp_zero_norm,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [30:0] csr_write_data
);

   localparam int AW = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int CW = AW + 1;

   localparam logic [4:0] S_CLEAR  = 5'd0;
   localparam logic [4:0] S_IDLE   = 5'd1;
   localparam logic [4:0] S_RDW    = 5'd2;
   localparam logic [4:0] S_MUL    = 5'd3;
   localparam logic [4:0] S_ACC    = 5'd4;
   localparam logic [4:0] S_LOSS   = 5'd5;
   localparam logic [4:0] S_HALF   = 5'd6;
   localparam logic [4:0] S_HALFW  = 5'd7;
   localparam logic [4:0] S_TAU    = 5'd8;
   localparam logic [4:0] S_TAUW   = 5'd9;
   localparam logic [4:0] S_UPRD   = 5'd10;
   localparam logic [4:0] S_UPMUL  = 5'd11;
   localparam logic [4:0] S_UPWR   = 5'd12;
   localparam logic [4:0] S_VALCLR = 5'd13;
   localparam logic [4:0] S_RDOUT  = 5'd14;
   localparam logic [4:0] S_OUT    = 5'd15;

   // memories
   logic signed [31:0] wmem [DIM];
   logic signed [31:0] smem [DIM];
   logic               svalid [DIM];
   logic signed [31:0] wrd_ff, srd_ff;
   logic               vrd_ff;

   logic [4:0]  state_ff, state_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [1:0]  mode_ff;
   logic [30:0] aggr_ff;
   logic [AW-1:0] idx_ff, idx_in;
   logic        idx_ok_ff, idx_ok_in;
   logic signed [31:0] val_ff, val_in;
   logic        pos_ff, pos_in;
   logic        last_ff, last_in;
   logic        rd_ff, rd_in;
   logic signed [63:0] dot_ff, dot_in;
   logic [63:0] norm_ff, norm_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [63:0] sq_ff, sq_in;
   logic [63:0] loss_ff, loss_in;
   logic [31:0] tau_ff, tau_in;
   logic        zn_ff, zn_in;
   logic        rv_ff, rv_in;
   logic        rk_ff, rk_in;
   logic [31:0] rval_ff, rval_in;
   logic        rzn_ff, rzn_in;

   // memory control
   logic          w_we, s_we, v_we, v_wd;
   logic [AW-1:0] w_wa, w_ra, s_a;
   logic signed [31:0] w_wd;
   logic          w_re, s_re;

   palu_pkg::div_req_type dreq;
   palu_pkg::div_rsp_type drsp;

   palu_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // dot-product multiplier
   logic signed [63:0] mul_p;
   assign mul_p = val_ff * wrd_ff;

   // saturating adders
   logic signed [64:0] dot_sum;
   logic [64:0]        norm_sum;
   assign dot_sum  = {dot_ff[63], dot_ff} + {prod_ff[63], prod_ff};
   assign norm_sum = {1'b0, norm_ff} + {1'b0, sq_ff};

   // update term
   logic [31:0]        xmag;
   logic [63:0]        upd_p;
   logic signed [49:0] wsum;
   logic               neg_x;
   logic [47:0]        dmag;
   assign neg_x = srd_ff[31];
   assign xmag  = neg_x ? 32'(-srd_ff) : srd_ff;

   // PA-II denominator: norm + 0.5/C, saturated
   logic [63:0] pa2_den;
   logic [64:0] pa2_sum;
   assign pa2_sum = {1'b0, norm_ff} + {1'b0, sq_ff};

   logic idx_in_range;
   assign idx_in_range = int'(req_element_index) < DIM;

   logic req_take;
   assign req_take = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= palu_pkg::MODE_PA;
         aggr_ff <= 31'd65536;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            palu_pkg::CSR_MODE: mode_ff <= csr_write_data[1:0];
            palu_pkg::CSR_AGGR: aggr_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign upd_p = 64'(tau_ff) * 64'(xmag);
   assign dmag  = upd_p[63:16];
   always_comb begin
      logic signed [49:0] d;
      d = (neg_x == pos_ff) ? -$signed({2'b00, dmag}) : $signed({2'b00, dmag});
      wsum = $signed({{18{wrd_ff[31]}}, wrd_ff}) + d;
   end
   assign pa2_den = pa2_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : pa2_sum[63:0];

   // sequencer
   always_comb begin
      logic [64:0] l;
      state_in = state_ff;
      ptr_in   = ptr_ff;
      idx_in   = idx_ff;
      idx_ok_in = idx_ok_ff;
      val_in   = val_ff;
      pos_in   = pos_ff;
      last_in  = last_ff;
      rd_in    = rd_ff;
      dot_in   = dot_ff;
      norm_in  = norm_ff;
      prod_in  = prod_ff;
      sq_in    = sq_ff;
      loss_in  = loss_ff;
      tau_in   = tau_ff;
      zn_in    = zn_ff;
      rv_in    = rv_ff && rsp_stall;
      rk_in    = rk_ff;
      rval_in  = rval_ff;
      rzn_in   = rzn_ff;
      w_we = 1'b0; w_wa = idx_ff; w_wd = val_ff;
      w_re = 1'b0; w_ra = idx_ff;
      s_we = 1'b0; s_re = 1'b0; s_a = idx_ff;
      v_we = 1'b0; v_wd = 1'b0;
      dreq = '0;
      l = '0;
      unique case (state_ff)
         S_CLEAR: begin
            w_we = 1'b1; w_wa = ptr_ff[AW-1:0]; w_wd = '0;
            v_we = 1'b1; s_a = ptr_ff[AW-1:0];
            ptr_in = ptr_ff + CW'(1);
            if (ptr_ff == CW'(DIM - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               idx_in    = AW'(req_element_index);
               idx_ok_in = idx_in_range;
               val_in    = req_element_value;
               pos_in    = req_class_label;
               last_in   = req_last_element;
               unique case (req_opcode)
                  palu_pkg::OP_SAMPLE: state_in = S_RDW;
                  palu_pkg::OP_LOAD: begin
                     w_we = idx_in_range;
                     w_wa = AW'(req_element_index);
                     w_wd = req_element_value;
                  end
                  palu_pkg::OP_READ: state_in = S_RDW;
                  default: ;
               endcase
               rd_in = (req_opcode == palu_pkg::OP_READ);
            end
         end
         S_RDW: begin
            w_re = 1'b1;
            if (rd_ff) begin
               state_in = S_RDOUT;
            end else begin
               if (idx_ok_ff) begin
                  s_we = 1'b1; v_we = 1'b1; v_wd = 1'b1;
               end
               state_in = S_MUL;
            end
         end
         S_RDOUT: begin
            // wait here while the previous result is still held
            if (!(rv_ff && rsp_stall)) begin
               rval_in  = idx_ok_ff ? wrd_ff : '0;
               rzn_in   = 1'b0;
               rk_in    = palu_pkg::KIND_READ;
               rv_in    = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_MUL: begin
            prod_in = mul_p;
            sq_in   = 64'(val_ff * val_ff);
            state_in = S_ACC;
         end
         S_ACC: begin
            if (idx_ok_ff) begin
               if (dot_sum[64] != dot_sum[63])
                  dot_in = dot_sum[64] ? 64'sh8000_0000_0000_0000
                                       : 64'sh7FFF_FFFF_FFFF_FFFF;
               else
                  dot_in = dot_sum[63:0];
               norm_in = norm_sum[64] ? '1 : norm_sum[63:0];
            end
            state_in = last_ff ? S_LOSS : S_IDLE;
         end
         S_LOSS: begin
            if (pos_ff)
               l = (dot_ff < 64'sh1_0000_0000) ?
                   65'h1_0000_0000 - {dot_ff[63], dot_ff} : '0;
            else
               l = (dot_ff > -64'sh1_0000_0000) ?
                   65'h1_0000_0000 + {dot_ff[63], dot_ff} : '0;
            loss_in = l[63:0];
            zn_in   = (norm_ff == '0);
            tau_in  = '0;
            if (norm_ff == '0) begin
               ptr_in = '0; state_in = S_UPRD;
            end else if (mode_ff == palu_pkg::MODE_PA2) begin
               // zero C makes 0.5/C infinite: no step
               if (aggr_ff == '0) begin
                  ptr_in = '0; state_in = S_UPRD;
               end else begin
                  dreq.start = 1'b1; dreq.num = 64'h8000_0000_0000;
                  dreq.den = {33'd0, aggr_ff}; dreq.frac_bits = '0;
                  state_in = S_HALFW;
               end
            end else begin
               dreq.start = 1'b1; dreq.num = l[63:0]; dreq.den = norm_ff;
               dreq.frac_bits = 7'd16; state_in = S_TAUW;
            end
         end
         S_HALFW: begin
            // stash half in loss_ff's partner: reuse sq_ff
            if (drsp.done) begin
               sq_in = drsp.quo;
               state_in = S_HALF;
            end
         end
         S_HALF: begin
            dreq.start = 1'b1; dreq.num = loss_ff;
            dreq.den = pa2_den;
            dreq.frac_bits = 7'd16;
            state_in = S_TAUW;
         end
         S_TAUW: begin
            if (drsp.done) begin
               state_in = S_TAU;
               tau_in = (drsp.sat || drsp.quo > 64'(palu_pkg::TAU_CAP)) ?
                        palu_pkg::TAU_CAP : drsp.quo[31:0];
            end
         end
         S_TAU: begin
            if (mode_ff == palu_pkg::MODE_PA1 && tau_ff > {1'b0, aggr_ff})
               tau_in = {1'b0, aggr_ff};
            ptr_in = '0; state_in = S_UPRD;
         end
         S_UPRD: begin
            w_re = 1'b1; w_ra = ptr_ff[AW-1:0];
            s_re = 1'b1; s_a = ptr_ff[AW-1:0];
            state_in = S_UPMUL;
         end
         S_UPMUL: begin
            state_in = S_UPWR;
         end
         S_UPWR: begin
            if (vrd_ff && tau_ff != '0) begin
               w_we = 1'b1; w_wa = ptr_ff[AW-1:0];
               w_wd = (wsum > 50'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                      (wsum < -50'sh8000_0000) ? 32'sh8000_0000 : wsum[31:0];
            end
            v_we = 1'b1; s_a = ptr_ff[AW-1:0];
            ptr_in = ptr_ff + CW'(1);
            state_in = (ptr_ff == CW'(DIM - 1)) ? S_OUT : S_UPRD;
         end
         S_OUT: begin
            dot_in  = '0; norm_in = '0;
            // wait here while the previous result is still held
            if (!(rv_ff && rsp_stall)) begin
               rk_in   = palu_pkg::KIND_LOSS;
               rval_in = (loss_ff[63:47] != '0) ? 32'h7FFF_FFFF : loss_ff[47:16];
               rzn_in  = zn_ff;
               rv_in   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (w_we) wmem[w_wa] <= w_wd;
      if (w_re) wrd_ff <= wmem[w_ra];
      if (s_we) smem[s_a] <= val_ff;
      if (s_re) srd_ff <= smem[s_a];
      if (v_we) svalid[s_a] <= v_wd;
      if (s_re) vrd_ff <= svalid[s_a];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ptr_ff   <= '0;
         rv_ff    <= 1'b0;
         dot_ff   <= '0;
         norm_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         rv_ff    <= rv_in;
         dot_ff   <= dot_in;
         norm_ff  <= norm_in;
      end
      idx_ff <= idx_in; idx_ok_ff <= idx_ok_in; val_ff <= val_in;
      pos_ff <= pos_in; last_ff <= last_in; rd_ff <= rd_in; prod_ff <= prod_in;
      sq_ff <= sq_in; loss_ff <= loss_in; tau_ff <= tau_in; zn_ff <= zn_in;
      rk_ff <= rk_in; rval_ff <= rval_in; rzn_ff <= rzn_in;
   end

   assign rsp_valid        = rv_ff;
   assign rsp_result_kind  = rk_ff;
   assign rsp_result_value = rval_ff;
   assign rsp_zero_norm    = rzn_ff;

`ifndef SYNTHESIS
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("accepted while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rsp_stall |=> rv_ff && $stable(rval_ff)) else $error("result lost");
   a_clear_after: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT |=> dot_ff == '0 && norm_ff == '0)
      else $error("accumulators not cleared");
`endif

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the passive-aggressive linear update block: a
// directed table of transactions and then random training samples, weight
// loads and reads are driven under several idle/stall patterns. Every loss
// and read result is checked against a fixed point predictor or a typed row.
// ----------------------------------------------------------------------------
module tb;

   localparam int NDIM      = 256;
   localparam int WDOG_MAX  = 200000;
   localparam int DRAIN_CYC = 1500;
   localparam int HOLD_CYC  = 3000;
   localparam int NROWS     = 22;

   typedef struct packed {
      logic        kind;
      logic [31:0] value;
      logic        zn;
   } palu_result_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  idx;
      logic [31:0] val;
      logic        lbl;
      logic        last;
      logic        chk;   // typed-in expectation present
      logic [31:0] exp_val;
      logic        exp_zn;
   } vec_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = '0;
   logic [7:0]  req_element_index = '0;
   logic signed [31:0] req_element_value = '0;
   logic        req_class_label = 1'b0;
   logic        req_last_element = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_result_kind;
   logic signed [31:0] rsp_result_value;
   logic        rsp_zero_norm;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = 1'b0;
   logic [30:0] csr_write_data = '0;

   passive_aggressive_linear_update_top #(.DIM(NDIM)) dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic [1:0]         pm_mode;
   logic [30:0]        pm_c;
   logic signed [31:0] pm_w [NDIM];
   logic signed [31:0] pm_x [NDIM];
   logic               pm_wr [NDIM];
   logic signed [63:0] pm_dot;
   logic [63:0]        pm_norm;

   palu_result_type expected_results[$];
   int  errors = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_rsp = 1'b0;
   int  hold_cycles = 0;
   int  quiet = 0;

   // floor(num*2^16/den) saturated at 32 bits
   function automatic logic [63:0] tau_quotient(logic [63:0] num, logic [63:0] den);
      logic [127:0] q;
      q = ({64'd0, num} << 16) / {64'd0, den};
      return (q > 128'hFFFF_FFFF) ? 64'hFFFF_FFFF : q[63:0];
   endfunction

   function automatic logic signed [31:0] clamp32(logic signed [64:0] v);
      if (v > 65'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -65'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // advance the predictor by one accepted transaction
   task automatic predict_transaction(logic [1:0] op, logic [7:0] idx,
                                      logic signed [31:0] val, logic lbl,
                                      logic last);
      logic signed [63:0]  prod;
      logic signed [64:0]  dsum;
      logic [64:0]         nsum;
      logic [63:0]         loss, tau, half, den, mag, dlt;
      logic signed [64:0]  nw;
      logic                zn;
      palu_result_type     r;
      prod = 64'(val) * 64'(pm_w[idx]);
      if (op == palu_pkg::OP_SAMPLE) begin
         pm_x[idx] = val;
         pm_wr[idx] = 1'b1;
         dsum = 65'(pm_dot) + 65'(prod);
         if (dsum > 65'sh0_7FFF_FFFF_FFFF_FFFF) pm_dot = 64'sh7FFF_FFFF_FFFF_FFFF;
         else if (dsum < -65'sh0_8000_0000_0000_0000) pm_dot = 64'sh8000_0000_0000_0000;
         else pm_dot = dsum[63:0];
         nsum = {1'b0, pm_norm} + {1'b0, 64'(64'(val) * 64'(val))};
         pm_norm = nsum[64] ? '1 : nsum[63:0];
         if (last) begin
            zn = (pm_norm == 0);
            loss = 0;
            tau = 0;
            if (lbl) begin
               if (pm_dot < 64'sh1_0000_0000) loss = 64'h1_0000_0000 - pm_dot;
            end else begin
               if (pm_dot > -64'sh1_0000_0000) loss = 64'h1_0000_0000 + pm_dot;
            end
            if (!zn) begin
               if (pm_mode == palu_pkg::MODE_PA2) begin
                  if (pm_c != 0) begin
                     half = (64'd1 << 47) / pm_c;
                     nsum = {1'b0, pm_norm} + {1'b0, half};
                     den = nsum[64] ? '1 : nsum[63:0];
                     tau = tau_quotient(loss, den);
                  end
               end else begin
                  tau = tau_quotient(loss, pm_norm);
                  if (pm_mode == palu_pkg::MODE_PA1 && tau > pm_c) tau = pm_c;
               end
            end
            for (int i = 0; i < NDIM; i++) begin
               if (pm_wr[i] && tau != 0) begin
                  mag = pm_x[i][31] ? -64'(pm_x[i]) : 64'(pm_x[i]);
                  dlt = (tau * mag) >> 16;
                  if (pm_x[i][31] == lbl) nw = 65'(pm_w[i]) - 65'(dlt);
                  else nw = 65'(pm_w[i]) + 65'(dlt);
                  pm_w[i] = clamp32(nw);
               end
               pm_wr[i] = 1'b0;
            end
            pm_dot = 0;
            pm_norm = 0;
            r.kind = palu_pkg::KIND_LOSS;
            r.value = (loss[63:16] > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : loss[47:16];
            r.zn = zn;
            expected_results.push_back(r);
         end
      end else if (op == palu_pkg::OP_LOAD) begin
         pm_w[idx] = val;
      end else if (op == palu_pkg::OP_READ) begin
         r.kind = palu_pkg::KIND_READ;
         r.value = pm_w[idx];
         r.zn = 1'b0;
         expected_results.push_back(r);
      end
   endtask

   // one transaction on the request channel; valid stays high after the
   // accepting edge until the next transaction or an idle cycle replaces it
   task automatic send_transaction(logic [1:0] op, logic [7:0] idx,
                                   logic [31:0] val, logic lbl, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_element_index <= idx;
      req_element_value <= val;
      req_class_label <= lbl;
      req_last_element <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_transaction(op, idx, val, lbl, last);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [30:0] data);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == palu_pkg::CSR_MODE) pm_mode = data[1:0];
      else pm_c = data;
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(5))
         0: return $urandom();
         1: return 32'(int'($urandom_range(131072)) - 65536);
         2: return 32'(int'($urandom_range(8192)) - 4096);
         3: return {{16{1'b0}}, 16'($urandom())};
         default: return 32'(int'($urandom_range(600000)) - 300000);
      endcase
   endfunction

   // random training sample of a few elements, mostly small indexes
   task automatic send_sample();
      int n;
      logic lbl;
      n = $urandom_range(1, 6);
      lbl = 1'($urandom_range(1));
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(9) == 0)
            send_transaction(2'($urandom_range(1, 2)), 8'($urandom()), rand_value(),
                             1'($urandom()), 1'($urandom()));
         send_transaction(palu_pkg::OP_SAMPLE, ($urandom_range(3) == 0) ? 8'($urandom())
                          : 8'($urandom_range(15)), rand_value(), lbl, k == n - 1);
      end
   endtask

   // result checking
   always @(posedge clock) begin
      palu_result_type got, exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_result_kind, rsp_result_value, rsp_zero_norm};
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result kind=%0d value=%h zn=%0d", $time,
                     got.kind, got.value, got.zn);
            errors++;
         end else begin
            exp_r = expected_results.pop_front();
            if (got.kind !== exp_r.kind) begin
               $display("%0t: kind expected %0d actual %0d", $time, exp_r.kind, got.kind);
               errors++;
            end
            if (got.value !== exp_r.value) begin
               $display("%0t: value expected %h actual %h", $time, exp_r.value, got.value);
               errors++;
            end
            if (got.zn !== exp_r.zn) begin
               $display("%0t: zero_norm expected %0d actual %0d", $time, exp_r.zn, got.zn);
               errors++;
            end
         end
      end
   end

   // receiver stall, with one long hold-off once requested
   always @(posedge clock) begin
      if (hold_rsp && hold_cycles < HOLD_CYC) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) quiet = 0;
      else quiet++;
      if (quiet >= WDOG_MAX) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   vec_row_type dir_table [NROWS] = '{
      // after reset the first and last weights read zero
      '{palu_pkg::OP_READ, 8'd0, 32'd0, 1'b0, 1'b0, 1'b1, 32'd0, 1'b0},
      '{palu_pkg::OP_READ, 8'd255, 32'd0, 1'b0, 1'b0, 1'b1, 32'd0, 1'b0},
      // zero norm sample: loss 1.0, no update
      '{palu_pkg::OP_SAMPLE, 8'd3, 32'd0, 1'b1, 1'b1, 1'b1, 32'h0001_0000, 1'b1},
      // load extremes and read back
      '{palu_pkg::OP_LOAD, 8'd0, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, 32'd0, 1'b0},
      '{palu_pkg::OP_READ, 8'd0, 32'd0, 1'b0, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b0},
      '{palu_pkg::OP_LOAD, 8'd255, 32'h8000_0000, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{palu_pkg::OP_READ, 8'd255, 32'd0, 1'b0, 1'b0, 1'b1, 32'h8000_0000, 1'b0},
      // unused opcode is ignored
      '{palu_pkg::OP_NONE, 8'd7, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 32'd0, 1'b0},
      // extreme products saturate the dot product
      '{palu_pkg::OP_SAMPLE, 8'd0, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{palu_pkg::OP_SAMPLE, 8'd0, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{palu_pkg::OP_SAMPLE, 8'd255, 32'h8000_0000, 1'b0, 1'b1, 1'b0, 32'd0, 1'b0},
      '{palu_pkg::OP_READ, 8'd0, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{palu_pkg::OP_READ, 8'd255, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      // repeated index, interleaved load mid-sample
      '{palu_pkg::OP_SAMPLE, 8'd5, 32'h0001_0000, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0},
      '{palu_pkg::OP_LOAD, 8'd6, 32'hFFFF_0000, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{palu_pkg::OP_SAMPLE, 8'd6, 32'h0000_8000, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0},
      '{palu_pkg::OP_SAMPLE, 8'd5, 32'hFFFE_0000, 1'b1, 1'b1, 1'b0, 32'd0, 1'b0},
      '{palu_pkg::OP_READ, 8'd5, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{palu_pkg::OP_READ, 8'd6, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      // normal positive and negative samples
      '{palu_pkg::OP_SAMPLE, 8'd1, 32'h0002_0000, 1'b0, 1'b1, 1'b0, 32'd0, 1'b0},
      '{palu_pkg::OP_SAMPLE, 8'd1, 32'h0000_0100, 1'b1, 1'b1, 1'b0, 32'd0, 1'b0},
      '{palu_pkg::OP_READ, 8'd1, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0}
   };

   initial begin
      palu_result_type typed;
      for (int i = 0; i < NDIM; i++) begin
         pm_w[i] = 0;
         pm_x[i] = 0;
         pm_wr[i] = 1'b0;
      end
      pm_dot = 0;
      pm_norm = 0;
      pm_mode = palu_pkg::MODE_PA;
      pm_c = 31'd65536;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; typed rows override the predictor's expectation
      foreach (dir_table[i]) begin
         send_transaction(dir_table[i].op, dir_table[i].idx, dir_table[i].val,
                          dir_table[i].lbl, dir_table[i].last);
         if (dir_table[i].chk) begin
            typed.kind = (dir_table[i].op == palu_pkg::OP_READ) ? palu_pkg::KIND_READ
                                                                : palu_pkg::KIND_LOSS;
            typed.value = dir_table[i].exp_val;
            typed.zn = dir_table[i].exp_zn;
            expected_results[$] = typed;
         end
      end

      // mode and C settings, extremes included
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin
               write_csr(palu_pkg::CSR_MODE, 31'(palu_pkg::MODE_PA));
               write_csr(palu_pkg::CSR_AGGR, 31'd1);
            end
            1: begin
               write_csr(palu_pkg::CSR_MODE, 31'(palu_pkg::MODE_PA1));
               write_csr(palu_pkg::CSR_AGGR, 31'd1);
            end
            2: write_csr(palu_pkg::CSR_AGGR, 31'h7FFF_FFFF);
            3: begin
               write_csr(palu_pkg::CSR_MODE, 31'(palu_pkg::MODE_PA2));
               write_csr(palu_pkg::CSR_AGGR, 31'd1);
            end
            4: write_csr(palu_pkg::CSR_AGGR, 31'h7FFF_FFFF);
            5: begin
               write_csr(palu_pkg::CSR_MODE, 31'(palu_pkg::MODE_SPARE));
               write_csr(palu_pkg::CSR_AGGR, 31'd32768);
            end
            6: begin
               write_csr(palu_pkg::CSR_MODE, 31'(palu_pkg::MODE_PA2));
               write_csr(palu_pkg::CSR_AGGR, 31'($urandom()));
            end
            default: begin
               write_csr(palu_pkg::CSR_MODE, 31'(palu_pkg::MODE_PA1));
               write_csr(palu_pkg::CSR_AGGR, 31'($urandom()));
            end
         endcase
         case (ph % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 71; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 71; end
            default: begin send_idle_pct = 9; recv_stall_pct = 9; end
         endcase
         if (ph == 2) hold_rsp <= 1'b1;
         for (int s = 0; s < 22; s++) begin
            if ($urandom_range(4) == 0)
               send_transaction(2'($urandom_range(1, 3)), 8'($urandom()), rand_value(),
                                1'($urandom()), 1'($urandom()));
            else
               send_sample();
            if (ph == 5 && s == 10) wait_drained();
         end
      end

      wait_drained();
      if (errors == 0 && expected_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
